>>> sv/gyro_offset_tracker_assert.svh
// Assertion macros shared by the RTL of the gyro offset tracker.
// Each macro expects clk and rst in scope.
`ifndef GYRO_OFFSET_TRACKER_ASSERT_SVH
`define GYRO_OFFSET_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GOTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GOTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gotr_pkg.sv
package gotr_pkg;

  localparam int QW      = 32;
  localparam int COEF_W  = 16;
  localparam int COUNT_W = 20;
  localparam int THRESH_W = 31;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [COEF_W-1:0]   COEF_RESET    = 16'd82;
  localparam logic [COUNT_W-1:0]  TIMEOUT_RESET = 20'd500;
  localparam logic [THRESH_W-1:0] THRESH_RESET  = 31'd196608;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [1:0] {
    REG_COEF    = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_THRESH  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [QW-1:0] gyro_x;
    logic signed [QW-1:0] gyro_y;
    logic signed [QW-1:0] gyro_z;
  } sample_t;

  typedef struct packed {
    logic signed [QW-1:0] corrected_x;
    logic signed [QW-1:0] corrected_y;
    logic signed [QW-1:0] corrected_z;
  } result_t;

  typedef struct packed {
    logic [COEF_W-1:0]   coef;
    logic [COUNT_W-1:0]  timeout;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic                adapt;
    logic [COEF_W-1:0]   coef;
    logic [THRESH_W-1:0] threshold;
  } axis_ctl_t;

endpackage

>>> sv/gotr_regs.sv
module gotr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gotr_pkg::ADDR_W-1:0] paddr,
  input  logic [gotr_pkg::DATA_W-1:0] pwdata,
  output logic [gotr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output gotr_pkg::cfg_t              cfg
);
  import gotr_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef      <= COEF_RESET;
      cfg.timeout   <= TIMEOUT_RESET;
      cfg.threshold <= THRESH_RESET;
    end else if (wr) begin
      case (idx)
        REG_COEF:    cfg.coef      <= pwdata[COEF_W-1:0];
        REG_TIMEOUT: cfg.timeout   <= pwdata[COUNT_W-1:0];
        REG_THRESH:  cfg.threshold <= pwdata[THRESH_W-1:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF:    prdata = DATA_W'(cfg.coef);
      REG_TIMEOUT: prdata = DATA_W'(cfg.timeout);
      REG_THRESH:  prdata = DATA_W'(cfg.threshold);
      default:     prdata = '0;
    endcase
  end

endmodule

>>> sv/gotr_axis.sv
module gotr_axis (
  input  logic                  clk,
  input  logic                  rst,
  input  gotr_pkg::q_t          raw,
  input  gotr_pkg::axis_ctl_t   ctl,
  output gotr_pkg::q_t          corrected,
  output logic                  moving
);
  import gotr_pkg::*;

  localparam int PROD_W = QW + COEF_W + 1;

  q_t                        bias;
  q_t                        bias_next;
  logic signed [QW:0]        diff;
  logic [QW-1:0]             mag;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [QW:0]        gain;
  logic signed [QW+1:0]      sum;

  // corrected = raw - bias, clamped to Q16.16
  assign diff = {raw[QW-1], raw} - {bias[QW-1], bias};

  always_comb begin
    if (diff[QW] != diff[QW-1]) begin
      corrected = diff[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      corrected = diff[QW-1:0];
    end
  end

  // magnitude of the most negative value comes out as 2^31 unsigned
  assign mag    = corrected[QW-1] ? (~corrected + 1'b1) : corrected;
  assign moving = mag > {1'b0, ctl.threshold};

  // round to nearest, ties toward plus infinity, by floor shift
  assign prod    = corrected * $signed({1'b0, ctl.coef});
  assign rounded = prod + PROD_W'(32768);
  assign gain    = rounded[PROD_W-1:16];

  assign sum = {bias[QW-1], bias[QW-1], bias} + {gain[QW], gain};

  always_comb begin
    if (sum[QW+1] != sum[QW-1] || sum[QW] != sum[QW-1]) begin
      bias_next = sum[QW+1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      bias_next = sum[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (ctl.adapt) begin
      bias <= bias_next;
    end
  end

endmodule

>>> sv/gyro_offset_tracker.sv
// Channel   Handshake                      Beat
// sample    sample_valid / sample_ready    gyro_x, gyro_y, gyro_z
// result    result_valid / result_ready    corrected_x, corrected_y, corrected_z
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One beat per cycle unless a held result stalls; a sample in the input register
// passes offset subtract, motion check and offset update into the result register.
// The offset feedback loop (subtract, gain multiply, saturating add) sets the clock.
// rst is synchronous: offsets and stillness count clear, registers take defaults.
// A held result stalls the pipe; sample_ready stays high while the input stage
// can move on.
`include "gyro_offset_tracker_assert.svh"

module gyro_offset_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  gotr_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output gotr_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gotr_pkg::ADDR_W-1:0] paddr,
  input  logic [gotr_pkg::DATA_W-1:0] pwdata,
  output logic [gotr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import gotr_pkg::*;

  cfg_t                 cfg;
  axis_ctl_t            ctl;
  logic                 s_valid;
  sample_t              s_data;
  logic                 advance;
  logic [2:0]           moving;
  logic                 any_moving;
  result_t              corr;
  logic [COUNT_W-1:0]   still_count;
  logic [COUNT_W-1:0]   still_count_next;
  logic                 elapsed;

  gotr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance      = s_valid && (!result_valid || result_ready);
  assign sample_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample_ready) begin
      s_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s_data <= sample;
    end
  end

  assign any_moving = |moving;
  assign elapsed    = still_count >= cfg.timeout;

  assign ctl.adapt     = advance && !any_moving && elapsed;
  assign ctl.coef      = cfg.coef;
  assign ctl.threshold = cfg.threshold;

  gotr_axis u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .raw       (s_data.gyro_x),
    .ctl       (ctl),
    .corrected (corr.corrected_x),
    .moving    (moving[0])
  );

  gotr_axis u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .raw       (s_data.gyro_y),
    .ctl       (ctl),
    .corrected (corr.corrected_y),
    .moving    (moving[1])
  );

  gotr_axis u_axis_z (
    .clk       (clk),
    .rst       (rst),
    .raw       (s_data.gyro_z),
    .ctl       (ctl),
    .corrected (corr.corrected_z),
    .moving    (moving[2])
  );

  always_comb begin
    if (any_moving) begin
      still_count_next = '0;
    end else if (!elapsed) begin
      still_count_next = still_count + 1'b1;
    end else begin
      still_count_next = still_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_count <= '0;
    end else if (advance) begin
      still_count <= still_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= corr;
    end
  end

  `GOTR_ASSERT_NEXT(a_move_clears, advance && any_moving, still_count == '0,
                    "stillness count not cleared on motion")
  `GOTR_ASSERT_NEXT(a_count_step, advance && !any_moving && !elapsed,
                    still_count == $past(still_count) + 1'b1,
                    "stillness count did not advance by one")
  `GOTR_ASSERT_NEXT(a_count_hold, !advance, $stable(still_count),
                    "stillness count moved without a beat")
  `GOTR_ASSERT_NEXT(a_beat_lands, advance, result_valid,
                    "advanced beat missing from result register")
  `GOTR_ASSERT_NOW(a_adapt_still, ctl.adapt, !any_moving && elapsed && s_valid,
                   "offset adapted outside a still, elapsed beat")

endmodule
